[rtl/core/chsid_pkg.sv]
// Shared types and codes for the chained hash set insert/dump block.
// No dependencies; imported by every module of the block but chsid_ram.
`default_nettype none

package chsid_pkg;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DUMP   = 1'b1;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_LISTED    = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   // Command bucket field holds any bucket index up to 126 and the count itself.
   localparam int CMD_BKT_W   = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] key;
      logic [3:0]         bucket_select;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] key_out;
      logic [3:0]         bucket_out;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic                 mode;
      logic signed [31:0]   key;
      logic [CMD_BKT_W-1:0] bucket;
      logic [3:0]           bucket_tag;
      logic                 in_range;
   } cmd_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SCAN_RD,
      B_SCAN_CMP,
      B_LIST_RD,
      B_LIST_OUT,
      B_RESULT
   } back_state_type;

endpackage

`default_nettype wire

[rtl/core/chsid_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module chsid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 80
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/chsid_front.sv]
// Front end: accepts request words, reduces insert keys to a bucket index.
// Depends on chsid_pkg; feeds the command queue.
`default_nettype none

module chsid_front import chsid_pkg::*; #(
   parameter int NUM_BUCKETS = 10
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         push,
   output cmd_type      cmd,
   input  wire logic    q_full
);

   localparam int REM_W = $clog2(NUM_BUCKETS);
   localparam int RW    = REM_W + 9;

   front_state_type    state_ff, state_in;
   logic               mode_ff;
   logic signed [31:0] key_ff;
   logic [3:0]         sel_ff;
   logic [31:0]        mag_ff;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [1:0]         step_ff;
   logic [31:0]        key_bits;
   logic [RW-1:0]      part;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.mode == MODE_DUMP) ? F_PUSH : F_DIV;
            end
         end
         F_DIV: begin
            if (step_ff == 2'd3) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // One byte of the magnitude per step: rem = (rem * 256 + byte) mod NUM_BUCKETS.
   always_comb begin
      part = RW'({rem_ff, mag_ff[31:24]});
      for (int k = 7; k >= 0; k--) begin
         if (part >= (RW'(NUM_BUCKETS) << k)) begin
            part = part - (RW'(NUM_BUCKETS) << k);
         end
      end
      rem_in = REM_W'(part);
   end

   always_comb begin
      key_bits       = req_data.key;
      req_stall      = (state_ff != F_IDLE);
      push           = (state_ff == F_PUSH) && !q_full;
      cmd.mode       = mode_ff;
      cmd.key        = key_ff;
      if (mode_ff == MODE_DUMP) begin
         cmd.bucket     = CMD_BKT_W'(sel_ff);
         cmd.bucket_tag = sel_ff;
         cmd.in_range   = (CMD_BKT_W'(sel_ff) < CMD_BKT_W'(NUM_BUCKETS));
      end else begin
         cmd.bucket     = CMD_BKT_W'(rem_ff);
         cmd.bucket_tag = 4'(rem_ff);
         cmd.in_range   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == F_IDLE) begin
            step_ff <= 2'd0;
         end else if (state_ff == F_DIV) begin
            step_ff <= step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid) begin
         mode_ff <= req_data.mode;
         key_ff  <= req_data.key;
         sel_ff  <= req_data.bucket_select;
         mag_ff  <= key_bits[31] ? (32'd0 - key_bits) : key_bits;
         rem_ff  <= '0;
      end else if (state_ff == F_DIV) begin
         mag_ff <= {mag_ff[23:0], 8'd0};
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/chsid_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on chsid_pkg.
`default_nettype none

module chsid_queue import chsid_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         valid,
   output cmd_type      head
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   assign full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[rtl/core/chsid_back.sv]
// Back end: bucket scan, append, dump sequencing and the response register.
// Depends on chsid_pkg and chsid_ram (key store).
`default_nettype none

module chsid_back import chsid_pkg::*; #(
   parameter int NUM_BUCKETS  = 10,
   parameter int BUCKET_DEPTH = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int ENTRIES = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int BW      = $clog2(NUM_BUCKETS);
   localparam int FW      = $clog2(BUCKET_DEPTH + 1);
   localparam int IW      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int AW      = $clog2(ENTRIES);

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [FW-1:0]  cur_fill_ff, cur_fill_in;
   logic [2:0]     status_ff, status_in;
   logic [FW-1:0]  fill_ff [NUM_BUCKETS];
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic [BW-1:0]  bkt, new_bkt;
   logic [FW-1:0]  new_fill;
   logic [AW-1:0]  base;
   logic           at_last, out_free, load;
   logic           ram_rd_en, ram_wr_en;
   logic [AW-1:0]  ram_rd_addr, ram_wr_addr;
   logic [31:0]    ram_rd_data;
   logic [31:0]    cmd_key_bits;

   assign bkt          = BW'(cmd_ff.bucket);
   assign new_bkt      = BW'(cmd.bucket);
   assign new_fill     = cmd.in_range ? fill_ff[new_bkt] : '0;
   assign base         = AW'(bkt) * AW'(BUCKET_DEPTH);
   assign at_last      = ((FW'(idx_ff) + FW'(1)) == cur_fill_ff);
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign cmd_key_bits = cmd_ff.key;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      cur_fill_in = cur_fill_ff;
      status_in   = status_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               cmd_in      = cmd;
               idx_in      = '0;
               cur_fill_in = new_fill;
               if (new_fill == '0) begin
                  status_in = (cmd.mode == MODE_DUMP) ? ST_EMPTY : ST_INSERTED;
                  state_in  = B_RESULT;
               end else begin
                  state_in = (cmd.mode == MODE_DUMP) ? B_LIST_RD : B_SCAN_RD;
               end
            end
         end
         B_SCAN_RD: state_in = B_SCAN_CMP;
         B_SCAN_CMP: begin
            if (ram_rd_data == cmd_key_bits) begin
               status_in = ST_DUPLICATE;
               state_in  = B_RESULT;
            end else if (at_last) begin
               status_in = (cur_fill_ff == FW'(BUCKET_DEPTH)) ? ST_FULL : ST_INSERTED;
               state_in  = B_RESULT;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = B_SCAN_RD;
            end
         end
         B_LIST_RD: state_in = B_LIST_OUT;
         B_LIST_OUT: begin
            if (out_free) begin
               if (at_last) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = B_LIST_RD;
               end
            end
         end
         B_RESULT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop     = (state_ff == B_IDLE) && cmd_valid;
      ram_rd_en   = (state_ff == B_SCAN_RD) || (state_ff == B_LIST_RD);
      ram_rd_addr = base + AW'(idx_ff);
      ram_wr_en   = (state_ff == B_RESULT) && out_free && (status_ff == ST_INSERTED);
      ram_wr_addr = base + AW'(cur_fill_ff);
      load        = 1'b0;
      rsp_in      = rsp_ff;
      unique case (state_ff)
         B_LIST_OUT: begin
            load              = out_free;
            rsp_in.status     = ST_LISTED;
            rsp_in.key_out    = ram_rd_data;
            rsp_in.bucket_out = cmd_ff.bucket_tag;
            rsp_in.last       = at_last;
         end
         B_RESULT: begin
            load              = out_free;
            rsp_in.status     = status_ff;
            rsp_in.key_out    = (cmd_ff.mode == MODE_DUMP) ? 32'sd0 : cmd_ff.key;
            rsp_in.bucket_out = cmd_ff.bucket_tag;
            rsp_in.last       = 1'b1;
         end
         default: load = 1'b0;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_wr_en) begin
            fill_ff[bkt] <= cur_fill_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      cur_fill_ff <= cur_fill_in;
      status_ff   <= status_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   chsid_ram #(
      .WIDTH (32),
      .DEPTH (ENTRIES)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (cmd_key_bits),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/chained_hash_set_insert_dump.sv]
// Top level of the chained hash set: front end, command queue, back end.
// Depends on chsid_pkg, chsid_front, chsid_queue, chsid_back, chsid_ram.
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_stall  req_type: mode, key, bucket_select
//   rsp      out  rsp_valid/rsp_stall  rsp_type: status, key_out, bucket_out, last
//
// Insert: the front end reduces the key (bucket = |key| mod NUM_BUCKETS, one byte per cycle),
//   then the back end reads and compares each stored key through the key store read port.
// Dump: the front end passes the word on; the back end reads and outputs each listed key (one EMPTY word when empty).
// Reset clears the bucket fill counts; the key store is not cleared.
// rsp_stall holds the response register; a two-word queue lets the front keep accepting
//   until it fills, then the front holds its word and stalls the input.
`default_nettype none

module chained_hash_set_insert_dump import chsid_pkg::*; #(
   parameter int NUM_BUCKETS  = 10,
   parameter int BUCKET_DEPTH = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    q_push, q_full, q_pop, q_valid;
   cmd_type q_in, q_head;

   chsid_front #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (q_push),
      .cmd       (q_in),
      .q_full    (q_full)
   );

   chsid_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   chsid_back #(
      .NUM_BUCKETS  (NUM_BUCKETS),
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_head),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command queue underflow");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("front end took a second word while busy");

   a_single_result_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_LISTED) |-> rsp_data.last)
      else $error("single-word response without last");

endmodule

`default_nettype wire

[tb/chsid_checker.sv]
// Checker for the chained hash set: watches both channels, keeps a shadow of the set,
// and compares every result word against the oldest owed word.
// Depends on chsid_pkg.
module chsid_checker import chsid_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BUCKETS  = 10;
   localparam int BUCKET_DEPTH = 8;
   localparam int REPORT_LIMIT = 10;

   logic signed [31:0] shadow_keys [NUM_BUCKETS][BUCKET_DEPTH];
   int                 shadow_fill [NUM_BUCKETS];
   rsp_type            owed_rsps [$];
   rsp_type            oldest;
   int                 fault_total = 0;

   function automatic logic [3:0] home_bucket(input logic signed [31:0] k);
      logic [31:0] raw;
      logic [31:0] mag;
      raw = k;
      mag = raw[31] ? (32'd0 - raw) : raw;
      return 4'(mag % NUM_BUCKETS);
   endfunction

   task automatic apply_to_shadow_set(input req_type w);
      rsp_type    r;
      logic [3:0] b;
      int         fill;
      int         i;
      bit         seen;
      if (w.mode == MODE_INSERT) begin
         b    = home_bucket(w.key);
         fill = shadow_fill[b];
         seen = 1'b0;
         for (i = 0; i < fill; i++)
            if (shadow_keys[b][i] == w.key)
               seen = 1'b1;
         r.key_out    = w.key;
         r.bucket_out = b;
         r.last       = 1'b1;
         if (seen) begin
            r.status = ST_DUPLICATE;
         end else if (fill >= BUCKET_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            shadow_keys[b][fill] = w.key;
            shadow_fill[b]       = fill + 1;
            r.status             = ST_INSERTED;
         end
         owed_rsps.push_back(r);
      end else begin
         fill = 0;
         if (w.bucket_select < NUM_BUCKETS)
            fill = shadow_fill[w.bucket_select];
         r.bucket_out = w.bucket_select;
         if (fill == 0) begin
            r.status  = ST_EMPTY;
            r.key_out = '0;
            r.last    = 1'b1;
            owed_rsps.push_back(r);
         end else begin
            for (i = 0; i < fill; i++) begin
               r.status  = ST_LISTED;
               r.key_out = shadow_keys[w.bucket_select][i];
               r.last    = (i == fill - 1);
               owed_rsps.push_back(r);
            end
         end
      end
   endtask

   task automatic flag(input string why, input rsp_type want, input rsp_type got);
      if (fault_total < REPORT_LIMIT)
         $display("%0t %s: want st=%0d key=%0d bkt=%0d last=%0b, %s",
                  $time, why, want.status, want.key_out, want.bucket_out, want.last,
                  $sformatf("got st=%0d key=%0d bkt=%0d last=%0b",
                            got.status, got.key_out, got.bucket_out, got.last));
      fault_total++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_rsps.delete();
         foreach (shadow_fill[i])
            shadow_fill[i] = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsps.size() == 0) begin
               flag("unexpected word", '0, rsp_data);
            end else begin
               oldest = owed_rsps.pop_front();
               if (rsp_data.status !== oldest.status || rsp_data.key_out !== oldest.key_out ||
                   rsp_data.bucket_out !== oldest.bucket_out || rsp_data.last !== oldest.last)
                  flag("word mismatch", oldest, rsp_data);
            end
         end
         if (req_valid && !req_stall)
            apply_to_shadow_set(req_data);
      end
      fail_count    <= fault_total;
      pending_count <= owed_rsps.size();
   end

endmodule

[tb/chained_hash_set_insert_dump_tb.sv]
// Top of the hash set testbench: clock, reset, word stimulus and the verdict.
// Depends on chsid_pkg, chsid_checker and the chained_hash_set_insert_dump block.
module chained_hash_set_insert_dump_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import chsid_pkg::*;

   localparam int HOLD_CYCLES  = 200;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 60;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int                 fail_total;
   int                 pending_rsps;
   int                 req_idle_pct = 0;
   int                 rsp_idle_pct = 0;
   bit                 hold_go = 1'b0;
   bit                 hold_done = 1'b0;
   int                 quiet_cycles = 0;
   logic signed [31:0] used_keys [$];

   always #6 clock = ~clock;

   chained_hash_set_insert_dump DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   chsid_checker set_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_total),
      .pending_count (pending_rsps)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   task automatic send_word(input req_type w);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= req_type'(($bits(req_type))'({$urandom, $urandom}));
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_insert(input logic signed [31:0] k);
      req_type w;
      w.mode          = MODE_INSERT;
      w.key           = k;
      w.bucket_select = 4'($urandom);
      used_keys.push_back(k);
      send_word(w);
   endtask

   task automatic send_dump(input logic [3:0] sel);
      req_type w;
      w.mode          = MODE_DUMP;
      w.key           = $urandom;
      w.bucket_select = sel;
      send_word(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsps != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 3 && used_keys.size() != 0)
         return used_keys[$urandom_range(used_keys.size() - 1)];
      if (roll < 6)
         return 32'($signed($urandom_range(100)) - 50);
      if (roll == 6) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic random_words(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(99) < 30)
            send_dump(($urandom_range(9) < 8) ? 4'($urandom_range(9)) : 4'($urandom_range(15, 10)));
         else
            send_insert(pick_key());
      end
   endtask

   initial begin
      int i;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 6;
      rsp_idle_pct = 46;
      send_insert(32'sd0);
      send_insert(32'sh8000_0000);
      send_insert(32'sh7fff_ffff);
      send_insert(-32'sd1);
      send_insert(32'sd1);
      send_insert(32'sd1);
      send_insert(32'sh8000_0000);
      for (i = 0; i < 8; i++)
         send_insert((i % 2) ? -(32'sd5 + 32'sd10 * i) : (32'sd5 + 32'sd10 * i));
      send_insert(32'sd85);
      send_insert(-32'sd15);
      send_dump(4'd5);
      send_dump(4'd1);
      send_dump(4'd8);
      send_dump(4'd3);
      send_dump(4'd15);
      send_dump(4'd10);
      send_dump(4'd7);
      random_words(70);
      drain();

      req_idle_pct = 46;
      rsp_idle_pct = 6;
      random_words(65);
      drain();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_go      = 1'b1;
      random_words(65);
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_total == 0 && pending_rsps == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/core/chsid_pkg.sv
rtl/core/chsid_ram.sv
rtl/core/chsid_front.sv
rtl/core/chsid_queue.sv
rtl/core/chsid_back.sv
rtl/core/chained_hash_set_insert_dump.sv
tb/chsid_checker.sv
tb/chained_hash_set_insert_dump_tb.sv
